@@ sv/lcdt_pkg.sv @@
`timescale 1ns / 1ps

package lcdt_pkg;

  localparam int DOT_W  = 10;
  localparam int LINE_W = 8;

  localparam int LINE_DOTS_DEF   = 456;
  localparam int FRAME_LINES_DEF = 154;

  localparam logic [LINE_W-1:0] FIRST_BLANK_LINE = 8'd144;
  localparam logic [DOT_W-1:0]  HBLANK_LAST_DOT  = 10'd204;
  localparam logic [DOT_W-1:0]  OBJRD_LAST_DOT   = 10'd284;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OBJRD  = 2'd2,
    MODE_VIDRD  = 2'd3
  } mode_t;

  // one tick word as held in the input register
  typedef struct packed {
    logic [7:0] cycles;
    logic       lcd_on;
    logic [7:0] lyc_value;
    logic       lyc_irq_enable;
    logic       clear_dots;
  } tick_t;

  // timing state carried from word to word
  typedef struct packed {
    logic [DOT_W-1:0]  dots;
    logic [LINE_W-1:0] line;
    mode_t             mode;
    logic              running;
    logic              coincide;
  } state_t;

  typedef struct packed {
    logic [LINE_W-1:0] line;
    mode_t             mode;
    logic              coincide;
    logic              line_end;
    logic              vblank_irq;
    logic              stat_irq;
    logic              enabled;
  } result_t;

  function automatic mode_t mode_for_dots(input logic [DOT_W-1:0] dots);
    mode_t m;
    if (dots <= HBLANK_LAST_DOT) begin
      m = MODE_HBLANK;
    end else if (dots <= OBJRD_LAST_DOT) begin
      m = MODE_OBJRD;
    end else begin
      m = MODE_VIDRD;
    end
    return m;
  endfunction

endpackage

@@ sv/lcdt_if.sv @@
`timescale 1ns / 1ps

interface lcdt_tick_if;
  logic       valid;
  logic       ready;
  logic [7:0] cycles;
  logic       lcd_on;
  logic [7:0] lyc_value;
  logic       lyc_irq_enable;
  logic       clear_dots;

  modport source (output valid, cycles, lcd_on, lyc_value, lyc_irq_enable, clear_dots,
                  input ready);
  modport sink   (input valid, cycles, lcd_on, lyc_value, lyc_irq_enable, clear_dots,
                  output ready);
endinterface

interface lcdt_status_if;
  logic       valid;
  logic       ready;
  logic [7:0] line;
  logic [1:0] mode;
  logic       coincide;
  logic       line_end;
  logic       vblank_irq;
  logic       stat_irq;
  logic       enabled;

  modport source (output valid, line, mode, coincide, line_end, vblank_irq, stat_irq,
                  enabled, input ready);
  modport sink   (input valid, line, mode, coincide, line_end, vblank_irq, stat_irq,
                  enabled, output ready);
endinterface

@@ sv/lcdt_step.sv @@
`timescale 1ns / 1ps

module lcdt_step import lcdt_pkg::*; #(
  parameter int LINE_DOTS   = LINE_DOTS_DEF,
  parameter int FRAME_LINES = FRAME_LINES_DEF
) (
  input  state_t  cur,
  input  tick_t   tick,
  output state_t  nxt,
  output result_t res
);

  localparam logic [DOT_W-1:0]  LineDotsW   = DOT_W'(LINE_DOTS);
  localparam logic [LINE_W-1:0] FrameLinesW = LINE_W'(FRAME_LINES);

  logic [DOT_W-1:0]  dots_start;
  logic [DOT_W-1:0]  dots_sum;
  logic [LINE_W-1:0] line_inc;
  logic [LINE_W-1:0] line_wrap;
  logic              run;

  assign dots_start = tick.clear_dots ? '0 : cur.dots;
  assign dots_sum   = dots_start + DOT_W'(tick.cycles);
  assign run        = cur.running | tick.lcd_on;
  assign line_inc   = cur.line + LINE_W'(1);
  assign line_wrap  = (line_inc >= FrameLinesW) ? line_inc - FrameLinesW : line_inc;

  always_comb begin
    nxt            = cur;
    nxt.dots       = dots_start;
    nxt.running    = run;
    res.line_end   = 1'b0;
    res.vblank_irq = 1'b0;
    res.stat_irq   = 1'b0;
    res.enabled    = run;

    if (run) begin
      nxt.dots = dots_sum;
      if (dots_sum >= LineDotsW) begin
        nxt.dots     = dots_sum - LineDotsW;
        res.line_end = 1'b1;
        nxt.coincide = (cur.line == tick.lyc_value);
        res.stat_irq = (cur.line == tick.lyc_value) & tick.lyc_irq_enable;
        nxt.line     = line_wrap;
        if (line_wrap == FIRST_BLANK_LINE) begin
          nxt.mode       = MODE_VBLANK;
          res.vblank_irq = 1'b1;
          // display switched off: park at line 0, dot 0
          if (!tick.lcd_on) begin
            nxt.running = 1'b0;
            nxt.line    = '0;
            nxt.dots    = '0;
          end
        end
      end
      if (nxt.line < FIRST_BLANK_LINE) begin
        nxt.mode = mode_for_dots(nxt.dots);
      end
    end

    res.line     = nxt.line;
    res.mode     = nxt.mode;
    res.coincide = nxt.coincide;
  end

endmodule

@@ sv/lcd_line_mode_timing.sv @@
`timescale 1ns / 1ps

// LCD line and mode timing. Each tick word carries the CPU time elapsed
// since the last one plus the live control bits (LCD enable, line compare
// value and its interrupt enable, dot-counter clear); each produces exactly
// one status word with the line number, mode, coincidence flag and the
// line-end, vertical-blank and coincidence interrupt pulses. Throughput is
// one word per clock while status words are taken: a tick waits in the input
// register while the combinational step logic (one add, one compare-subtract
// on the 10-bit dot counter, one on the 8-bit line) updates the state. The
// status word then goes into the output register when the step advances,
// which a held-off status word can delay. While a status word is held off,
// an empty input register still takes a tick; tick ready then drops until
// the status word goes. At most one line ends per tick; an LCD stop takes
// effect only on reaching line 144.
module lcd_line_mode_timing import lcdt_pkg::*; #(
  parameter int LINE_DOTS   = LINE_DOTS_DEF,
  parameter int FRAME_LINES = FRAME_LINES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  lcdt_tick_if.sink     tick,
  lcdt_status_if.source status
);

  // input register
  logic    in_vld;
  tick_t   in_word;
  // timing state
  state_t  st;
  state_t  st_next;
  // output register
  logic    out_vld;
  result_t out_word;
  result_t res_next;

  logic    advance;

  // step the state when a word is held and the output slot is free or draining
  assign advance    = in_vld & (~out_vld | status.ready);
  assign tick.ready = ~in_vld | advance;

  lcdt_step #(
    .LINE_DOTS   (LINE_DOTS),
    .FRAME_LINES (FRAME_LINES)
  ) u_step (
    .cur  (st),
    .tick (in_word),
    .nxt  (st_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (tick.valid && tick.ready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_word.cycles         <= tick.cycles;
      in_word.lcd_on         <= tick.lcd_on;
      in_word.lyc_value      <= tick.lyc_value;
      in_word.lyc_irq_enable <= tick.lyc_irq_enable;
      in_word.clear_dots     <= tick.clear_dots;
    end
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      st.dots     <= '0;
      st.line     <= '0;
      st.mode     <= MODE_HBLANK;
      st.running  <= 1'b0;
      st.coincide <= 1'b0;
      out_vld     <= 1'b0;
    end else begin
      if (advance) begin
        st      <= st_next;
        out_vld <= 1'b1;
      end else if (status.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= res_next;
    end
  end

  assign status.valid      = out_vld;
  assign status.line       = out_word.line;
  assign status.mode       = out_word.mode;
  assign status.coincide   = out_word.coincide;
  assign status.line_end   = out_word.line_end;
  assign status.vblank_irq = out_word.vblank_irq;
  assign status.stat_irq   = out_word.stat_irq;
  assign status.enabled    = out_word.enabled;

  // line counter stays inside the frame
  a_line_range: assert property (@(posedge clk) disable iff (rst)
    st.line < LINE_W'(FRAME_LINES))
    else $error("line counter outside frame");

  // at most one line per tick keeps the dot counter below a line length
  a_dots_range: assert property (@(posedge clk) disable iff (rst)
    st.dots < DOT_W'(LINE_DOTS))
    else $error("dot counter not below line length");

  // interrupt pulses only come with a finished line while running
  a_irq_line_end: assert property (@(posedge clk) disable iff (rst)
    out_vld && (out_word.vblank_irq || out_word.stat_irq) |->
      out_word.line_end && out_word.enabled)
    else $error("interrupt pulse without line end");

  // a stop parks the timing at line 0 in hblank
  a_stop_park: assert property (@(posedge clk) disable iff (rst)
    advance && st.running && !st_next.running |=>
      st.line == '0 && st.dots == '0 && st.mode == MODE_HBLANK)
    else $error("stop did not park timing");

endmodule
